// ===== rtl/core/cau_pkg.sv =====
`default_nettype none

package cau_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    FUNC_ADD,
    FUNC_SUB,
    FUNC_MUL,
    FUNC_DIV,
    FUNC_EQ
  } func_e;

endpackage

`default_nettype wire

// ===== rtl/core/complex_arith_unit.sv =====
`default_nettype none

// Complex ALU on signed fixed-point operands: add, subtract, complex multiply, complex divide
// and equality test, with saturation and overflow / divide-by-zero flags. One item is taken
// every clock cycle while the output is not stalled. The pipeline's depth is set by the
// divider, which resolves one quotient bit per pipeline stage (WORD_BITS+1 stages) after
// one stage that flags quotients too large to represent; the operand, product, sum,
// divider-preparation and output registers add the rest. The multiply and add/subtract
// results travel down the same pipeline so items leave in order. A skid register behind
// the output stage captures a stalled result so that the pipeline can advance past it;
// while the skid register holds it, the whole pipeline and the input stall until the
// result is taken.
module complex_arith_unit
  import cau_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  func_i,
  input  logic signed [WORD_BITS-1:0] a_re_i,
  input  logic signed [WORD_BITS-1:0] a_im_i,
  input  logic signed [WORD_BITS-1:0] b_re_i,
  input  logic signed [WORD_BITS-1:0] b_im_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [WORD_BITS-1:0] res_re_o,
  output logic signed [WORD_BITS-1:0] res_im_o,
  output logic                        is_equal_o,
  output logic                        div_zero_o,
  output logic                        overflow_o
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int DW = 2 * W + 1;
  localparam int RW = SW + F;
  localparam int ND = W + 2;

  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [2:0]          func;
    logic signed [W-1:0] res_re;
    logic signed [W-1:0] res_im;
    logic                ovf;
    logic                eq;
    logic                dz;
    logic                neg_re;
    logic                neg_im;
    logic                big_re;
    logic                big_im;
    logic [DW-1:0]       den;
    logic [RW-1:0]       rem_re;
    logic [RW-1:0]       rem_im;
    logic [W:0]          q_re;
    logic [W:0]          q_im;
  } dv_t;

  typedef struct packed {
    logic signed [W-1:0] res_re;
    logic signed [W-1:0] res_im;
    logic                eq;
    logic                dz;
    logic                ovf;
  } res_t;

  // Returns {overflow, saturated word}.
  function automatic logic [W:0] sat_w(input logic signed [SW-1:0] x);
    logic [SW-W:0] hi;
    hi = x[SW-1:W-1];
    if (hi == '0 || hi == '1) begin
      return {1'b0, x[W-1:0]};
    end else if (x[SW-1]) begin
      return {1'b1, WMIN};
    end else begin
      return {1'b1, WMAX};
    end
  endfunction

  function automatic logic [W:0] div_out(input logic neg, input logic big,
                                         input logic [W:0] q);
    logic signed [SW-1:0] m;
    logic [W:0]           r;
    m = signed'(SW'(q));
    if (neg) begin
      m = -m;
    end
    r = sat_w(m);
    if (big) begin
      r = neg ? {1'b1, WMIN} : {1'b1, WMAX};
    end
    return r;
  endfunction

  logic adv;
  logic skid_v_q;

  // Stage 0: operands.
  logic                v0_q;
  logic [2:0]          f0_q;
  logic signed [W-1:0] a0_q, b0_q, c0_q, d0_q;

  // Stage 1: products and add/subtract results.
  logic                 v1_q;
  logic [2:0]           f1_q;
  logic signed [PW-1:0] p_ac_q, p_bd_q, p_ad_q, p_bc_q, p_cc_q, p_dd_q;
  logic signed [PW-1:0] p_ac_d, p_bd_d, p_ad_d, p_bc_d, p_cc_d, p_dd_d;
  logic signed [W-1:0]  r1_re_q, r1_im_q, r1_re_d, r1_im_d;
  logic                 ovf1_q, ovf1_d, eq1_q, eq1_d;

  // Stage 2: sums of products.
  logic                 v2_q;
  logic [2:0]           f2_q;
  logic signed [SW-1:0] m_re_q, m_im_q, n_re_q, n_im_q;
  logic [DW-1:0]        den_q;
  logic signed [W-1:0]  r2_re_q, r2_im_q;
  logic                 ovf2_q, eq2_q;

  // Stage 3 and the divider steps.
  logic [ND:0] vdv_q;
  dv_t         dv0_d;
  dv_t         dv_q [ND+1];
  dv_t         dv_d [ND+1];

  // Output stage and skid.
  logic vo_q;
  res_t out_q, out_d, skid_q, shown;

  assign adv        = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_comb begin
    logic [W:0] s_re;
    logic [W:0] s_im;
    s_re    = '0;
    s_im    = '0;
    p_ac_d  = a0_q * c0_q;
    p_bd_d  = b0_q * d0_q;
    p_ad_d  = a0_q * d0_q;
    p_bc_d  = b0_q * c0_q;
    p_cc_d  = c0_q * c0_q;
    p_dd_d  = d0_q * d0_q;
    if (f0_q == FUNC_ADD) begin
      s_re = sat_w(SW'(a0_q) + SW'(c0_q));
      s_im = sat_w(SW'(b0_q) + SW'(d0_q));
    end else if (f0_q == FUNC_SUB) begin
      s_re = sat_w(SW'(a0_q) - SW'(c0_q));
      s_im = sat_w(SW'(b0_q) - SW'(d0_q));
    end
    r1_re_d = s_re[W-1:0];
    r1_im_d = s_im[W-1:0];
    ovf1_d  = s_re[W] | s_im[W];
    eq1_d   = (f0_q == FUNC_EQ) && (a0_q == c0_q) && (b0_q == d0_q);
  end

  // Operand preparation for the divider; multiply results are finished here.
  always_comb begin
    logic [W:0]    t_re;
    logic [W:0]    t_im;
    logic [SW-1:0] mag_re;
    logic [SW-1:0] mag_im;
    t_re          = sat_w(m_re_q >>> F);
    t_im          = sat_w(m_im_q >>> F);
    mag_re        = n_re_q[SW-1] ? SW'(-n_re_q) : SW'(n_re_q);
    mag_im        = n_im_q[SW-1] ? SW'(-n_im_q) : SW'(n_im_q);
    dv0_d.func    = f2_q;
    dv0_d.res_re  = r2_re_q;
    dv0_d.res_im  = r2_im_q;
    dv0_d.ovf     = ovf2_q;
    if (f2_q == FUNC_MUL) begin
      dv0_d.res_re = t_re[W-1:0];
      dv0_d.res_im = t_im[W-1:0];
      dv0_d.ovf    = t_re[W] | t_im[W];
    end
    dv0_d.eq      = eq2_q;
    dv0_d.dz      = (f2_q == FUNC_DIV) && (den_q == '0);
    dv0_d.neg_re  = n_re_q[SW-1];
    dv0_d.neg_im  = n_im_q[SW-1];
    dv0_d.big_re  = 1'b0;
    dv0_d.big_im  = 1'b0;
    dv0_d.den     = den_q;
    dv0_d.rem_re  = RW'(mag_re) << F;
    dv0_d.rem_im  = RW'(mag_im) << F;
    dv0_d.q_re    = '0;
    dv0_d.q_im    = '0;
  end

  // Restoring division, one quotient bit per stage. The first step only checks whether
  // the quotient reaches 2^(W+1), which always saturates.
  always_comb begin
    int k;
    logic [RW-1:0] dx;
    k       = 0;
    dx      = '0;
    dv_d[0] = dv0_d;
    for (int j = 0; j < ND; j++) begin
      dv_d[j+1] = dv_q[j];
      dx        = RW'(dv_q[j].den);
      if (j == 0) begin
        dv_d[j+1].big_re = (dv_q[j].rem_re >> (W + 1)) >= dx;
        dv_d[j+1].big_im = (dv_q[j].rem_im >> (W + 1)) >= dx;
      end else begin
        k = W + 1 - j;
        if ((dv_q[j].rem_re >> k) >= dx) begin
          dv_d[j+1].rem_re  = dv_q[j].rem_re - (dx << k);
          dv_d[j+1].q_re[k] = 1'b1;
        end
        if ((dv_q[j].rem_im >> k) >= dx) begin
          dv_d[j+1].rem_im  = dv_q[j].rem_im - (dx << k);
          dv_d[j+1].q_im[k] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    logic [W:0] o_re;
    logic [W:0] o_im;
    o_re         = div_out(dv_q[ND].neg_re, dv_q[ND].big_re, dv_q[ND].q_re);
    o_im         = div_out(dv_q[ND].neg_im, dv_q[ND].big_im, dv_q[ND].q_im);
    out_d.res_re = dv_q[ND].res_re;
    out_d.res_im = dv_q[ND].res_im;
    out_d.eq     = dv_q[ND].eq;
    out_d.dz     = dv_q[ND].dz;
    out_d.ovf    = dv_q[ND].ovf;
    if (dv_q[ND].func == FUNC_DIV) begin
      if (dv_q[ND].dz) begin
        out_d.res_re = '0;
        out_d.res_im = '0;
        out_d.ovf    = 1'b0;
      end else begin
        out_d.res_re = o_re[W-1:0];
        out_d.res_im = o_im[W-1:0];
        out_d.ovf    = o_re[W] | o_im[W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q     <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      vdv_q    <= '0;
      vo_q     <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (adv) begin
        v0_q  <= in_valid_i;
        v1_q  <= v0_q;
        v2_q  <= v1_q;
        vdv_q <= {vdv_q[ND-1:0], v2_q};
        vo_q  <= vdv_q[ND];
      end
      if (!skid_v_q) begin
        skid_v_q <= vo_q && out_stall_i;
      end else begin
        skid_v_q <= out_stall_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f0_q    <= func_i;
      a0_q    <= a_re_i;
      b0_q    <= a_im_i;
      c0_q    <= b_re_i;
      d0_q    <= b_im_i;
      f1_q    <= f0_q;
      p_ac_q  <= p_ac_d;
      p_bd_q  <= p_bd_d;
      p_ad_q  <= p_ad_d;
      p_bc_q  <= p_bc_d;
      p_cc_q  <= p_cc_d;
      p_dd_q  <= p_dd_d;
      r1_re_q <= r1_re_d;
      r1_im_q <= r1_im_d;
      ovf1_q  <= ovf1_d;
      eq1_q   <= eq1_d;
      f2_q    <= f1_q;
      m_re_q  <= SW'(p_ac_q) - SW'(p_bd_q);
      m_im_q  <= SW'(p_ad_q) + SW'(p_bc_q);
      n_re_q  <= SW'(p_ac_q) + SW'(p_bd_q);
      n_im_q  <= SW'(p_bc_q) - SW'(p_ad_q);
      den_q   <= DW'(SW'(p_cc_q) + SW'(p_dd_q));
      r2_re_q <= r1_re_q;
      r2_im_q <= r1_im_q;
      ovf2_q  <= ovf1_q;
      eq2_q   <= eq1_q;
      for (int j = 0; j <= ND; j++) begin
        dv_q[j] <= dv_d[j];
      end
      out_q   <= out_d;
    end
    if (!skid_v_q) begin
      skid_q <= out_q;
    end
  end

  assign shown       = skid_v_q ? skid_q : out_q;
  assign out_valid_o = skid_v_q | vo_q;
  assign res_re_o    = shown.res_re;
  assign res_im_o    = shown.res_im;
  assign is_equal_o  = shown.eq;
  assign div_zero_o  = shown.dz;
  assign overflow_o  = shown.ovf;

endmodule

`default_nettype wire

// ===== rtl/core/cau_checker.sv =====
`default_nettype none

module cau_sva
  import cau_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [WORD_BITS-1:0] res_re_o,
  input wire logic [WORD_BITS-1:0] res_im_o,
  input wire logic                 is_equal_o,
  input wire logic                 div_zero_o,
  input wire logic                 overflow_o
);

  localparam logic [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // An equality result carries nothing else.
  a_eq_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_equal_o |->
      res_re_o == '0 && res_im_o == '0 && !overflow_o && !div_zero_o)
    else $error("equality item carries a value or flag");

  // A divide by zero gives zero and no other flag.
  a_dz_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && div_zero_o |->
      res_re_o == '0 && res_im_o == '0 && !overflow_o && !is_equal_o)
    else $error("divide-by-zero item carries a value or flag");

  // Overflow means at least one part sits at a rail.
  a_ovf_rail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |->
      res_re_o == WMAX || res_re_o == WMIN || res_im_o == WMAX || res_im_o == WMIN)
    else $error("overflow flagged without a saturated part");

  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(res_re_o) && $stable(res_im_o) && $stable(overflow_o))
    else $error("stalled item changed");

endmodule

bind complex_arith_unit cau_sva #(.WORD_BITS(WORD_BITS)) u_cau_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .res_re_o    (res_re_o),
  .res_im_o    (res_im_o),
  .is_equal_o  (is_equal_o),
  .div_zero_o  (div_zero_o),
  .overflow_o  (overflow_o)
);

`default_nettype wire
